// ===== rtl/nrfrw_pkg.sv =====
// Shared types and constants for the receive filter and ring writer.
package nrfrw_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 1518;
	localparam int unsigned MIN_FRAME_BYTES = 14;
	localparam int unsigned MAX_RES = 9;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HOLD    = 2'd1;
	localparam logic [1:0] PH_STORE   = 2'd2;
	localparam logic [1:0] PH_DISCARD = 2'd3;

	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_STORED   = 2'd1;
	localparam logic [1:0] EV_OVERFLOW = 2'd2;

	localparam logic [2:0] REG_ENABLE  = 3'd0;
	localparam logic [2:0] REG_MODE    = 3'd1;
	localparam logic [2:0] REG_STATION = 3'd2;
	localparam logic [2:0] REG_HASH    = 3'd3;
	localparam logic [2:0] REG_START   = 3'd4;
	localparam logic [2:0] REG_STOP    = 3'd5;
	localparam logic [2:0] REG_INITPG  = 3'd6;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [10:0] frame_length;
		logic [7:0]  boundary_page;
		logic        last_byte;
	} rx_in_t;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic [1:0]  event_res;
		logic        last_result;
		logic [7:0]  next_write_page;
	} rx_res_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic [15:0] wp_next(input logic [15:0] wp, input logic [7:0] start,
		input logic [7:0] stop);
		logic [16:0] n;
		n = {1'b0, wp} + 17'd1;
		if (n[16:8] >= {1'b0, stop}) begin
			n = {1'b0, start, 8'd0};
		end
		return n[15:0];
	endfunction

endpackage

// ===== rtl/nic_receive_filter_ring_writer_core.sv =====
// Receive address filter and ring buffer writer, top level.
//
// Input channel (in_valid/in_ready/in_data) takes one frame byte per
// transaction. Each transaction is handled in the cycle it is accepted and
// its results (zero to nine buffer writes or events) land in a result
// register. The output channel (out_valid/out_ready/out_data) presents
// them one per cycle while the receiver is ready.
// Plain data bytes give one result and flow at one byte per cycle; the sixth
// byte of an accepted frame (six writes) and the final byte (nine writes)
// hold the input off while the result register drains, one result a cycle.
// A new byte is taken in the same cycle the last pending result is taken.
// When the receiver stalls, results stay put and input stalls once pending
// results remain. Reset clears the configuration and frame state, the write
// page to zero, the CRC to all ones and the frame state to idle.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data; writing
// the initial write page also loads the current write page.
module nic_receive_filter_ring_writer_core import nrfrw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  rx_in_t      in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rx_res_t     out_data
);

	logic        enable_q;
	logic [2:0]  mode_q;
	logic [47:0] station_q;
	logic [63:0] hash_q;
	logic [7:0]  start_q, stop_q;

	logic [7:0]  cur_q;
	logic [10:0] pos_q, len_q;
	logic [47:0] dest_q;
	logic [31:0] crc_q;
	logic [15:0] wp_q;
	logic [7:0]  ffp_q;
	logic [1:0]  ph_q;

	rx_res_t     res_q [MAX_RES];
	logic [3:0]  rem_q, idx_q;

	logic        in_fire, out_fire;

	logic [7:0]  cur_d;
	logic [10:0] pos_d, len_d;
	logic [47:0] dest_d;
	logic [31:0] crc_d;
	logic [15:0] wp_d;
	logic [7:0]  ffp_d;
	logic [1:0]  ph_d;
	logic [3:0]  n_d;
	rx_res_t     r_d [MAX_RES];

	assign out_valid = (rem_q != 4'd0);
	assign out_data  = res_q[idx_q];
	assign out_fire  = out_valid && out_ready;
	assign in_ready  = (rem_q == 4'd0) || ((rem_q == 4'd1) && out_ready);
	assign in_fire   = in_valid && in_ready;

	always_comb begin
		logic        go;
		logic        acc;
		logic [5:0]  hbit;
		logic signed [9:0] ring, free_pg, pages;
		logic [8:0]  pg;
		logic [7:0]  nxt;
		logic [8:0]  nsum;
		logic [31:0] fcs;
		logic [11:0] total;
		logic [15:0] base;
		cur_d  = (cfg_we && (cfg_index == REG_INITPG)) ? cfg_data[7:0] : cur_q;
		pos_d  = pos_q;
		len_d  = len_q;
		dest_d = dest_q;
		crc_d  = crc_q;
		wp_d   = wp_q;
		ffp_d  = ffp_q;
		ph_d   = ph_q;
		n_d    = 4'd0;
		go     = 1'b1;
		acc    = 1'b0;
		hbit   = '0;
		ring   = '0;
		free_pg = '0;
		pages  = '0;
		pg     = '0;
		nxt    = '0;
		nsum   = '0;
		fcs    = '0;
		total  = '0;
		base   = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			r_d[i] = '0;
		end
		if (in_fire) begin
			if (ph_d == PH_IDLE) begin
				len_d  = in_data.frame_length;
				pos_d  = '0;
				dest_d = '0;
				crc_d  = CRC_INIT;
				if (!enable_q || (len_d < 11'(MIN_FRAME_BYTES))
					|| (len_d > 11'(MAX_FRAME_BYTES))) begin
					ph_d = in_data.last_byte ? PH_IDLE : PH_DISCARD;
					go = 1'b0;
				end else begin
					ph_d = PH_HOLD;
				end
			end
			pg = 9'(({1'b0, len_d} + 12'd263) >> 8);
			pages = 10'(pg);
			if (!go) begin
			end else if (ph_d == PH_HOLD) begin
				dest_d = dest_d | ({40'd0, in_data.frame_byte} << {pos_d[2:0], 3'b000});
				crc_d = crc_byte(crc_d, in_data.frame_byte);
				pos_d = pos_d + 11'd1;
				if (in_data.last_byte) begin
					ph_d = PH_IDLE;
				end else if (pos_d >= 11'd6) begin
					hbit = 6'((~crc_d) >> 26);
					if (mode_q[2]) acc = 1'b1;
					else if (dest_d == station_q) acc = 1'b1;
					else if (dest_d == 48'hFFFFFFFFFFFF) acc = mode_q[0];
					else if (dest_d[0]) acc = mode_q[1] && hash_q[hbit];
					else acc = 1'b0;
					if (!acc) begin
						ph_d = PH_DISCARD;
					end else begin
						ring = 10'(stop_q) - 10'(start_q);
						if (in_data.boundary_page >= cur_d)
							free_pg = 10'(in_data.boundary_page) - 10'(cur_d);
						else
							free_pg = ring - (10'(cur_d) - 10'(in_data.boundary_page));
						if ((ring <= 10'sd0) || (pages >= free_pg)) begin
							ph_d = PH_DISCARD;
							r_d[0].event_res = EV_OVERFLOW;
							n_d = 4'd1;
						end else begin
							ffp_d = cur_d;
							wp_d = {cur_d, 8'd4};
							for (int i = 0; i < 6; i++) begin
								r_d[i].write_valid = 1'b1;
								r_d[i].write_address = wp_d;
								r_d[i].write_data = dest_d[8*i +: 8];
								r_d[i].event_res = EV_NONE;
								wp_d = wp_next(wp_d, start_q, stop_q);
							end
							n_d = 4'd6;
							ph_d = PH_STORE;
						end
					end
				end
			end else if (ph_d == PH_STORE) begin
				crc_d = crc_byte(crc_d, in_data.frame_byte);
				r_d[0].write_valid = 1'b1;
				r_d[0].write_address = wp_d;
				r_d[0].write_data = in_data.frame_byte;
				wp_d = wp_next(wp_d, start_q, stop_q);
				n_d = 4'd1;
				pos_d = pos_d + 11'd1;
				if (pos_d >= len_d) begin
					fcs = ~crc_d;
					total = {1'b0, len_d} + 12'd8;
					nsum = {1'b0, ffp_d} + pg;
					nxt = nsum[7:0];
					base = {ffp_d, 8'd0};
					for (int i = 0; i < 4; i++) begin
						r_d[1+i].write_valid = 1'b1;
						r_d[1+i].write_address = wp_d;
						r_d[1+i].write_data = fcs[8*i +: 8];
						wp_d = wp_next(wp_d, start_q, stop_q);
					end
					if (nxt >= stop_q) nxt = start_q + nxt - stop_q;
					r_d[5].write_valid = 1'b1;
					r_d[5].write_address = base;
					r_d[5].write_data = 8'h01;
					r_d[6].write_valid = 1'b1;
					r_d[6].write_address = base + 16'd1;
					r_d[6].write_data = nxt;
					r_d[7].write_valid = 1'b1;
					r_d[7].write_address = base + 16'd2;
					r_d[7].write_data = total[7:0];
					r_d[8].write_valid = 1'b1;
					r_d[8].write_address = base + 16'd3;
					r_d[8].write_data = {4'd0, total[11:8]};
					r_d[8].event_res = EV_STORED;
					n_d = 4'd9;
					cur_d = nxt;
					ph_d = in_data.last_byte ? PH_IDLE : PH_DISCARD;
				end else if (in_data.last_byte) begin
					ph_d = PH_IDLE;
				end
			end else begin
				if (in_data.last_byte) ph_d = PH_IDLE;
			end
		end
		for (int i = 0; i < MAX_RES; i++) begin
			r_d[i].next_write_page = cur_d;
			r_d[i].last_result = (4'(i) + 4'd1 == n_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			mode_q    <= '0;
			station_q <= '0;
			hash_q    <= '0;
			start_q   <= '0;
			stop_q    <= '0;
			cur_q     <= '0;
			pos_q     <= '0;
			len_q     <= '0;
			dest_q    <= '0;
			crc_q     <= CRC_INIT;
			wp_q      <= '0;
			ffp_q     <= '0;
			ph_q      <= PH_IDLE;
			rem_q     <= '0;
			idx_q     <= '0;
		end else begin
			cur_q  <= cur_d;
			pos_q  <= pos_d;
			len_q  <= len_d;
			dest_q <= dest_d;
			crc_q  <= crc_d;
			wp_q   <= wp_d;
			ffp_q  <= ffp_d;
			ph_q   <= ph_d;
			if (in_fire && (n_d != 4'd0)) begin
				rem_q <= n_d;
				idx_q <= '0;
			end else if (out_fire) begin
				rem_q <= rem_q - 4'd1;
				idx_q <= idx_q + 4'd1;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE:  enable_q  <= cfg_data[0];
					REG_MODE:    mode_q    <= cfg_data[2:0];
					REG_STATION: station_q <= cfg_data[47:0];
					REG_HASH:    hash_q    <= cfg_data;
					REG_START:   start_q   <= cfg_data[7:0];
					REG_STOP:    stop_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (n_d != 4'd0)) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= r_d[i];
			end
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the receive address filter and ring buffer writer.
module tb_top;
	import nrfrw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;
	rx_in_t in_data;
	rx_res_t out_data;

	nic_receive_filter_ring_writer_core dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// shadow registers and state
	logic        m_en;
	logic [2:0]  m_mode;
	logic [47:0] m_station;
	logic [63:0] m_hash;
	logic [7:0]  m_start, m_stop;
	logic [7:0]  m_page, m_first;
	logic [10:0] m_pos, m_len;
	logic [47:0] m_dest;
	logic [31:0] m_crc;
	logic [15:0] m_wp;
	logic [1:0]  m_phase;

	rx_res_t expected_writes[$];
	int errors = 0;
	int cycles = 0;
	bit idle_on = 1;
	int in_count = 0;

	function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	function automatic logic [7:0] pages_needed();
		logic [11:0] t;
		t = {1'b0, m_len} + 12'd263;
		return {4'd0, t[11:8]};
	endfunction

	rx_res_t step_buf[$];

	task automatic push_write(input logic v, input logic [15:0] a, input logic [7:0] d,
		input logic [1:0] ev);
		rx_res_t r;
		r = '0;
		r.write_valid = v; r.write_address = a; r.write_data = d; r.event_res = ev;
		step_buf.push_back(r);
	endtask

	task automatic push_data(input logic [7:0] d);
		logic [16:0] n;
		push_write(1'b1, m_wp, d, EV_NONE);
		n = {1'b0, m_wp} + 17'd1;
		if (n[16:8] >= {1'b0, m_stop}) n = {1'b0, m_start, 8'd0};
		m_wp = n[15:0];
	endtask

	function automatic bit frame_accepted();
		if (m_mode[2]) return 1;
		if (m_dest == m_station) return 1;
		if (m_dest == 48'hFFFFFFFFFFFF) return m_mode[0];
		if (m_dest[0]) return m_mode[1] && m_hash[(~m_crc) >> 26];
		return 0;
	endfunction

	task automatic predict_byte(input rx_in_t it);
		int ring, cur, bn, freep;
		logic [31:0] fcs;
		logic [11:0] total;
		logic [8:0] nxt;
		logic [15:0] base;
		step_buf.delete();
		if (m_phase == PH_IDLE) begin
			m_len = it.frame_length; m_pos = 0; m_dest = 0; m_crc = 32'hFFFFFFFF;
			if (!m_en || it.frame_length < MIN_FRAME_BYTES
				|| it.frame_length > MAX_FRAME_BYTES) begin
				m_phase = it.last_byte ? PH_IDLE : PH_DISCARD;
				return;
			end
			m_phase = PH_HOLD;
		end
		if (m_phase == PH_HOLD) begin
			m_dest = m_dest | (48'(it.frame_byte) << (8 * m_pos[2:0]));
			m_crc = crc_step(m_crc, it.frame_byte);
			m_pos++;
			if (it.last_byte) begin m_phase = PH_IDLE; return; end
			if (m_pos < 6) return;
			if (!frame_accepted()) begin m_phase = PH_DISCARD; return; end
			ring = int'(m_stop) - int'(m_start);
			cur = m_page; bn = it.boundary_page;
			freep = (bn >= cur) ? bn - cur : ring - (cur - bn);
			if (ring <= 0 || int'(pages_needed()) >= freep) begin
				m_phase = PH_DISCARD;
				push_write(1'b0, 16'd0, 8'd0, EV_OVERFLOW);
			end else begin
				m_first = m_page;
				m_wp = {m_page, 8'd4};
				for (int i = 0; i < 6; i++) push_data(m_dest[8*i +: 8]);
				m_phase = PH_STORE;
			end
		end else if (m_phase == PH_STORE) begin
			m_crc = crc_step(m_crc, it.frame_byte);
			push_data(it.frame_byte);
			m_pos++;
			if (m_pos >= m_len) begin
				fcs = ~m_crc;
				total = {1'b0, m_len} + 12'd8;
				nxt = {1'b0, m_first + pages_needed()};
				base = {m_first, 8'd0};
				for (int i = 0; i < 4; i++) push_data(fcs[8*i +: 8]);
				if (nxt[7:0] >= m_stop) nxt = {1'b0, m_start + nxt[7:0] - m_stop};
				push_write(1'b1, base, 8'h01, EV_NONE);
				push_write(1'b1, base + 16'd1, nxt[7:0], EV_NONE);
				push_write(1'b1, base + 16'd2, total[7:0], EV_NONE);
				push_write(1'b1, base + 16'd3, {4'd0, total[11:8]}, EV_STORED);
				m_page = nxt[7:0];
				m_phase = it.last_byte ? PH_IDLE : PH_DISCARD;
			end else if (it.last_byte) m_phase = PH_IDLE;
		end else begin
			if (it.last_byte) m_phase = PH_IDLE;
			return;
		end
		foreach (step_buf[i]) step_buf[i].next_write_page = m_page;
		if (step_buf.size() > 0) step_buf[step_buf.size()-1].last_result = 1'b1;
		foreach (step_buf[i]) expected_writes.push_back(step_buf[i]);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		while (expected_writes.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_we = 1; cfg_index = idx; cfg_data = val;
		case (idx)
			REG_ENABLE:  m_en = val[0];
			REG_MODE:    m_mode = val[2:0];
			REG_STATION: m_station = val[47:0];
			REG_HASH:    m_hash = val;
			REG_START:   m_start = val[7:0];
			REG_STOP:    m_stop = val[7:0];
			REG_INITPG:  m_page = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic send_byte(input rx_in_t it);
		int gap;
		if (clk) @(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1; in_data = it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_byte(it);
		in_count++;
		@(negedge clk);
		in_valid = 0;
		in_data = rx_in_t'(28'($urandom()));
	endtask

	// receiver side: random stall bursts
	initial begin
		int stall;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready = 0;
				stall = $urandom_range(1, 19);
				repeat (stall) @(negedge clk);
			end
			out_ready = 1;
		end
	end

	// result checker
	always @(posedge clk) begin
		rx_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_writes.size() == 0) begin
				$error("unexpected transaction %h", out_data);
				errors++;
			end else begin
				e = expected_writes.pop_front();
				if (out_data.write_valid !== e.write_valid) begin
					$error("write_valid exp %h got %h", e.write_valid, out_data.write_valid);
					errors++;
				end
				if (out_data.write_address !== e.write_address) begin
					$error("write_address exp %h got %h", e.write_address,
						out_data.write_address);
					errors++;
				end
				if (out_data.write_data !== e.write_data) begin
					$error("write_data exp %h got %h", e.write_data, out_data.write_data);
					errors++;
				end
				if (out_data.event_res !== e.event_res) begin
					$error("event_res exp %h got %h", e.event_res, out_data.event_res);
					errors++;
				end
				if (out_data.last_result !== e.last_result) begin
					$error("last_result exp %h got %h", e.last_result, out_data.last_result);
					errors++;
				end
				if (out_data.next_write_page !== e.next_write_page) begin
					$error("next_write_page exp %h got %h", e.next_write_page,
						out_data.next_write_page);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic drain();
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// one frame; nbytes < len gives an early end marker, extra bytes a missing one
	task automatic send_frame(input logic [47:0] dest, input int len, input int nbytes,
		input logic [7:0] bnry);
		rx_in_t it;
		for (int i = 0; i < nbytes; i++) begin
			it.frame_byte = (i < 6) ? dest[8*i +: 8] : 8'($urandom());
			it.frame_length = 11'(len);
			it.boundary_page = bnry;
			it.last_byte = (i == nbytes - 1);
			send_byte(it);
		end
	endtask

	task automatic setup_ring(input logic [7:0] s, input logic [7:0] e, input logic [7:0] p);
		drain();
		write_reg(REG_START, 64'(s));
		write_reg(REG_STOP, 64'(e));
		write_reg(REG_INITPG, 64'(p));
	endtask

	task automatic test_directed();
		setup_ring(8'h40, 8'h60, 8'h40);
		write_reg(REG_STATION, 64'h665544332211);
		write_reg(REG_HASH, 64'hFFFFFFFFFFFFFFFF);
		write_reg(REG_MODE, 64'd3);
		// disabled: dropped
		send_frame(48'h665544332211, 14, 3, 8'h3F);
		write_reg(REG_ENABLE, 64'd1);
		send_frame(48'h665544332211, 14, 14, 8'h3F);
		send_frame(48'hFFFFFFFFFFFF, 20, 20, 8'h3F);
		send_frame(48'h000000000001, 16, 16, 8'h3F);
		send_frame(48'h000000000002, 16, 16, 8'h3F);
		send_frame(48'h665544332211, 13, 13, 8'h3F);
		send_frame(48'h665544332211, 1519, 3, 8'h3F);
		send_frame(48'h665544332211, 30, 10, 8'h3F);
		send_frame(48'h665544332211, 14, 18, 8'h3F);
		send_frame(48'h665544332211, 14, 4, 8'h3F);
		// overflow: boundary just ahead
		send_frame(48'h665544332211, 20, 8, m_page + 8'd1);
		drain();
	endtask

	task automatic test_modes();
		write_reg(REG_MODE, 64'd4);
		send_frame(48'h0000DEADBEEE, 14, 14, 8'h3F);
		write_reg(REG_MODE, 64'd0);
		write_reg(REG_HASH, 64'd0);
		send_frame(48'hFFFFFFFFFFFF, 14, 8, 8'h3F);
		send_frame(48'h000000000003, 14, 8, 8'h3F);
		drain();
	endtask

	task automatic test_bad_ring();
		setup_ring(8'h10, 8'h10, 8'h10);
		send_frame(48'h665544332211, 14, 8, 8'h05);
		// ring at top of address space, next page wraps to the ring start
		setup_ring(8'hFC, 8'hFF, 8'hFE);
		write_reg(REG_MODE, 64'd4);
		send_frame(48'h123456789ABC, 20, 20, 8'hFD);
		drain();
	endtask

	task automatic test_random(input int nframes);
		logic [47:0] d;
		int len, nb;
		for (int f = 0; f < nframes; f++) begin
			if (f % 10 == 0) begin
				drain();
				write_reg(REG_MODE, 64'($urandom_range(0, 7)));
				write_reg(REG_HASH, {$urandom(), $urandom()});
				write_reg(REG_STATION, 64'({16'($urandom()), 32'($urandom())}));
				write_reg(REG_ENABLE, 64'($urandom_range(0, 9) != 0));
				setup_ring(8'($urandom_range(0, 250)), 8'($urandom_range(0, 255)), 8'($urandom()));
				if (m_stop <= m_start)
					write_reg(REG_STOP, 64'(m_start + 8'($urandom_range(1, 5))));
				if (m_stop <= m_start) write_reg(REG_STOP, 64'hFF);
				write_reg(REG_INITPG, 64'(m_start));
			end
			case ($urandom_range(0, 3))
				0: d = m_station;
				1: d = 48'hFFFFFFFFFFFF;
				2: d = {16'($urandom()), 31'($urandom()), 1'b1};
				default: d = {16'($urandom()), 32'($urandom())};
			endcase
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
				: $urandom_range(14, 18);
			nb = (len < 1) ? 1 : (len > 40 ? $urandom_range(1, 20) : len);
			if ($urandom_range(0, 7) == 0) nb = $urandom_range(1, (len > 37) ? 40 : len + 3);
			if (nb < 1) nb = 1;
			send_frame(d, len, nb, ($urandom_range(0, 3) == 0) ? 8'($urandom())
				: m_start + 8'($urandom_range(0, 3)) - 8'd1);
		end
		drain();
	endtask

	initial begin
		arst_n = 0; cfg_we = 0; cfg_index = REG_ENABLE; cfg_data = '0;
		in_valid = 0; in_data = '0;
		m_en = 0; m_mode = 0; m_station = 0; m_hash = 0; m_start = 0; m_stop = 0;
		m_page = 0; m_first = 0; m_pos = 0; m_len = 0; m_dest = 0;
		m_crc = 32'hFFFFFFFF; m_wp = 0; m_phase = PH_IDLE;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_modes();
		test_bad_ring();
		test_random(2);
		idle_on = 0;
		test_random(1);
		drain();
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/nrfrw_pkg.sv
rtl/nic_receive_filter_ring_writer_core.sv
tb/sv/tb_top.sv
